/* rtl/srecord_s19_framer_defines.svh */
// Assertion macros shared by the S-record framer RTL.
// No dependencies; included by the files that carry assertions.
`ifndef SRECORD_S19_FRAMER_DEFINES_SVH
`define SRECORD_S19_FRAMER_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define SFR_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define SFR_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* rtl/sfr_pkg.sv */
// Types and constants for the S-record framer.
// No dependencies; used by sfr_out and srecord_s19_framer.
package sfr_pkg;

	localparam logic [2:0] OP_BYTE  = 3'd0;
	localparam logic [2:0] OP_WORD  = 3'd1;
	localparam logic [2:0] OP_START = 3'd2;
	localparam logic [2:0] OP_FLUSH = 3'd3;
	localparam logic [2:0] OP_END   = 3'd4;

	localparam logic [7:0] HDR_BYTES = 8'd3;   // two address bytes + checksum
	localparam logic [7:0] S9_COUNT  = 8'h03;

	localparam logic KIND_S1 = 1'b0;
	localparam logic KIND_S9 = 1'b1;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_WRITE,
		ST_F_CNT,
		ST_F_AHI,
		ST_F_ALO,
		ST_F_RD,
		ST_F_DAT,
		ST_F_SUM,
		ST_S9_CNT,
		ST_S9_HI,
		ST_S9_LO,
		ST_S9_SUM
	} state_t;

	typedef struct packed {
		logic       kind;
		logic [7:0] rbyte;
		logic       first;
		logic       last;
	} result_t;

endpackage

/* rtl/sfr_buf.sv */
// Record data buffer: one write port, one registered read port.
// Uses no package items; instantiated by srecord_s19_framer.
module sfr_buf #(
	parameter int DEPTH = 32,
	parameter int AW    = 5
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [7:0]    wdata,
	input  logic          re,
	input  logic [AW-1:0] raddr,
	output logic [7:0]    rdata
);

	logic [7:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// read data holds until the next read
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

/* rtl/sfr_out.sv */
// Output holding register for emitted record bytes.
// Depends on sfr_pkg (result_t); instantiated by srecord_s19_framer.
module sfr_out (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             load,
	input  sfr_pkg::result_t din,
	output logic             slot_free,
	output logic             out_valid,
	input  logic             out_ready,
	output logic             record_kind,
	output logic [7:0]       record_byte,
	output logic             first_of_record,
	output logic             last_of_run
);

	logic             valid_q;
	sfr_pkg::result_t res_q;

	assign slot_free = !valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (slot_free) begin
			valid_q <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (load && slot_free) begin
			res_q <= din;
		end
	end

	assign out_valid       = valid_q;
	assign record_kind     = res_q.kind;
	assign record_byte     = res_q.rbyte;
	assign first_of_record = res_q.first;
	assign last_of_run     = res_q.last;

endmodule

/* rtl/srecord_s19_framer.sv */
// Motorola S1/S9 record framer, byte level. An item is taken only while the sequencer is idle.
// A flush of n buffered bytes emits n+4 record bytes; each data byte is one buffer
// read and then one emit, and an S9 record adds four record bytes. Output stalls hold
// the sequencer in its emit states. Depends on sfr_pkg, sfr_buf, sfr_out and
// srecord_s19_framer_defines.svh.
`include "srecord_s19_framer_defines.svh"
module srecord_s19_framer #(
	parameter int MAX_DATA_BYTES = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [2:0]  opcode,
	input  logic [15:0] value,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        record_kind,
	output logic [7:0]  record_byte,
	output logic        first_of_record,
	output logic        last_of_run
);

	localparam int CW = $clog2(MAX_DATA_BYTES + 1);
	localparam int AW = (MAX_DATA_BYTES > 1) ? $clog2(MAX_DATA_BYTES) : 1;
	localparam logic [CW-1:0] FULL = CW'(MAX_DATA_BYTES);

	sfr_pkg::state_t  state_q, state_nxt;
	logic [CW-1:0]    fill_q, idx_q;
	logic [15:0]      addr_q, addr_adv;
	logic [7:0]       cs_q, count_byte, rdata;
	logic [15:0]      pend_q;
	logic [1:0]       pend_cnt_q;
	logic             end_q;
	logic             wr_en, rd_en, load, slot_free, more_flush;
	sfr_pkg::result_t res;

	assign in_ready   = (state_q == sfr_pkg::ST_IDLE);
	assign count_byte = 8'(fill_q) + sfr_pkg::HDR_BYTES;
	assign addr_adv   = addr_q + 16'(fill_q);
	// a word into a one-byte buffer can flush twice
	assign more_flush = (32'(pend_cnt_q) > MAX_DATA_BYTES);

	sfr_buf #(.DEPTH(MAX_DATA_BYTES), .AW(AW)) u_buf (
		.clk   (clk),
		.we    (wr_en),
		.waddr (fill_q[AW-1:0]),
		.wdata (pend_q[7:0]),
		.re    (rd_en),
		.raddr (idx_q[AW-1:0]),
		.rdata (rdata)
	);

	sfr_out u_out (
		.clk             (clk),
		.arst_n          (arst_n),
		.load            (load),
		.din             (res),
		.slot_free       (slot_free),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.record_kind     (record_kind),
		.record_byte     (record_byte),
		.first_of_record (first_of_record),
		.last_of_run     (last_of_run)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= sfr_pkg::ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		load      = 1'b0;
		wr_en     = 1'b0;
		rd_en     = 1'b0;
		res       = '0;
		case (state_q)
			sfr_pkg::ST_IDLE: begin
				if (in_valid) begin
					case (opcode)
						sfr_pkg::OP_BYTE, sfr_pkg::OP_WORD: state_nxt = sfr_pkg::ST_WRITE;
						sfr_pkg::OP_FLUSH:
							state_nxt = (fill_q == '0) ? sfr_pkg::ST_IDLE : sfr_pkg::ST_F_CNT;
						sfr_pkg::OP_END:
							state_nxt = (fill_q == '0) ? sfr_pkg::ST_S9_CNT : sfr_pkg::ST_F_CNT;
						default: state_nxt = sfr_pkg::ST_IDLE;
					endcase
				end
			end
			sfr_pkg::ST_WRITE: begin
				if (pend_cnt_q == 2'd0) begin
					state_nxt = sfr_pkg::ST_IDLE;
				end else if (fill_q == FULL) begin
					state_nxt = sfr_pkg::ST_F_CNT;
				end else begin
					wr_en = 1'b1;
					if (pend_cnt_q == 2'd1) begin
						state_nxt = sfr_pkg::ST_IDLE;
					end
				end
			end
			sfr_pkg::ST_F_CNT: begin
				res = '{sfr_pkg::KIND_S1, count_byte, 1'b1, 1'b0};
				if (slot_free) begin
					load      = 1'b1;
					state_nxt = sfr_pkg::ST_F_AHI;
				end
			end
			sfr_pkg::ST_F_AHI: begin
				res = '{sfr_pkg::KIND_S1, addr_q[15:8], 1'b0, 1'b0};
				if (slot_free) begin
					load      = 1'b1;
					state_nxt = sfr_pkg::ST_F_ALO;
				end
			end
			sfr_pkg::ST_F_ALO: begin
				res = '{sfr_pkg::KIND_S1, addr_q[7:0], 1'b0, 1'b0};
				if (slot_free) begin
					load      = 1'b1;
					state_nxt = sfr_pkg::ST_F_RD;
				end
			end
			sfr_pkg::ST_F_RD: begin
				rd_en     = 1'b1;
				state_nxt = sfr_pkg::ST_F_DAT;
			end
			sfr_pkg::ST_F_DAT: begin
				res = '{sfr_pkg::KIND_S1, rdata, 1'b0, 1'b0};
				if (slot_free) begin
					load      = 1'b1;
					state_nxt = (idx_q + 1'b1 == fill_q) ? sfr_pkg::ST_F_SUM : sfr_pkg::ST_F_RD;
				end
			end
			sfr_pkg::ST_F_SUM: begin
				res = '{sfr_pkg::KIND_S1, ~(cs_q + count_byte), 1'b0, !end_q && !more_flush};
				if (slot_free) begin
					load = 1'b1;
					if (end_q) begin
						state_nxt = sfr_pkg::ST_S9_CNT;
					end else if (pend_cnt_q != 2'd0) begin
						state_nxt = sfr_pkg::ST_WRITE;
					end else begin
						state_nxt = sfr_pkg::ST_IDLE;
					end
				end
			end
			sfr_pkg::ST_S9_CNT: begin
				res = '{sfr_pkg::KIND_S9, sfr_pkg::S9_COUNT, 1'b1, 1'b0};
				if (slot_free) begin
					load      = 1'b1;
					state_nxt = sfr_pkg::ST_S9_HI;
				end
			end
			sfr_pkg::ST_S9_HI: begin
				res = '{sfr_pkg::KIND_S9, pend_q[15:8], 1'b0, 1'b0};
				if (slot_free) begin
					load      = 1'b1;
					state_nxt = sfr_pkg::ST_S9_LO;
				end
			end
			sfr_pkg::ST_S9_LO: begin
				res = '{sfr_pkg::KIND_S9, pend_q[7:0], 1'b0, 1'b0};
				if (slot_free) begin
					load      = 1'b1;
					state_nxt = sfr_pkg::ST_S9_SUM;
				end
			end
			sfr_pkg::ST_S9_SUM: begin
				res = '{sfr_pkg::KIND_S9,
					~(sfr_pkg::S9_COUNT + pend_q[15:8] + pend_q[7:0]), 1'b0, 1'b1};
				if (slot_free) begin
					load      = 1'b1;
					state_nxt = sfr_pkg::ST_IDLE;
				end
			end
			default: state_nxt = sfr_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q     <= '0;
			idx_q      <= '0;
			addr_q     <= '0;
			cs_q       <= '0;
			pend_cnt_q <= '0;
			end_q      <= 1'b0;
		end else begin
			case (state_q)
				sfr_pkg::ST_IDLE: begin
					if (in_valid) begin
						case (opcode)
							sfr_pkg::OP_BYTE: begin
								pend_cnt_q <= 2'd1;
								end_q      <= 1'b0;
							end
							sfr_pkg::OP_WORD: begin
								pend_cnt_q <= 2'd2;
								end_q      <= 1'b0;
							end
							sfr_pkg::OP_START: begin
								addr_q <= value;
								fill_q <= '0;
								cs_q   <= value[15:8] + value[7:0];
							end
							sfr_pkg::OP_FLUSH: begin
								pend_cnt_q <= 2'd0;
								end_q      <= 1'b0;
							end
							sfr_pkg::OP_END: begin
								pend_cnt_q <= 2'd0;
								end_q      <= 1'b1;
							end
							default: ;
						endcase
					end
				end
				sfr_pkg::ST_WRITE: begin
					if (wr_en) begin
						fill_q     <= fill_q + 1'b1;
						cs_q       <= cs_q + pend_q[7:0];
						pend_cnt_q <= pend_cnt_q - 2'd1;
					end
				end
				sfr_pkg::ST_F_CNT: idx_q <= '0;
				sfr_pkg::ST_F_DAT: begin
					if (slot_free) begin
						idx_q <= idx_q + 1'b1;
					end
				end
				sfr_pkg::ST_F_SUM: begin
					if (slot_free) begin
						addr_q <= addr_adv;
						fill_q <= '0;
						cs_q   <= addr_adv[15:8] + addr_adv[7:0];
					end
				end
				sfr_pkg::ST_S9_SUM: begin
					if (slot_free) begin
						fill_q <= '0;
						cs_q   <= addr_q[15:8] + addr_q[7:0];
						end_q  <= 1'b0;
					end
				end
				default: ;
			endcase
		end
	end

	// pending bytes shift down as they are buffered; also holds the S9 address
	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			pend_q <= value;
		end else if (wr_en) begin
			pend_q <= {8'h00, pend_q[15:8]};
		end
	end

	`SFR_ASSERT_NXT(a_full_flushes,
		(state_q == sfr_pkg::ST_WRITE) && (pend_cnt_q != 2'd0) && (fill_q == FULL),
		state_q == sfr_pkg::ST_F_CNT, "full buffer written without flush")
	`SFR_ASSERT_NXT(a_flush_empties,
		(state_q == sfr_pkg::ST_F_SUM) && slot_free,
		fill_q == '0, "buffer not emptied after record")
	`SFR_ASSERT_IMP(a_idle_checksum,
		(state_q == sfr_pkg::ST_IDLE) && (fill_q == '0),
		cs_q == 8'(addr_q[15:8] + addr_q[7:0]), "checksum out of step with address")
	`SFR_ASSERT_IMP(a_fill_bound,
		wr_en, fill_q < FULL, "write beyond buffer depth")

endmodule

/* test/tb_srecord_s19_framer.sv */
// Testbench for srecord_s19_framer: directed and random record streams, checked byte by byte.
// Depends on sfr_pkg (opcodes, record kinds, result_t) and the framer RTL.
module tb_srecord_s19_framer;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int REC_MAX    = 32;
	localparam int TIMEOUT_NS = 2_000_000;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [2:0]  opcode = sfr_pkg::OP_BYTE;
	logic [15:0] value = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic        record_kind;
	logic [7:0]  record_byte;
	logic        first_of_record;
	logic        last_of_run;

	// idle probabilities in percent
	int unsigned send_idle_pct = 38;
	int unsigned recv_idle_pct = 48;
	int unsigned mismatch_count = 0;
	int unsigned items_sent = 0;

	// framer state mirror
	logic [7:0]  shadow_data [REC_MAX];
	int unsigned shadow_fill = 0;
	logic [15:0] shadow_addr = '0;
	logic [7:0]  shadow_sum = '0;

	sfr_pkg::result_t expected_record_bytes[$];

	srecord_s19_framer #(.MAX_DATA_BYTES(REC_MAX)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.opcode(opcode),
		.value(value),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.record_kind(record_kind),
		.record_byte(record_byte),
		.first_of_record(first_of_record),
		.last_of_run(last_of_run)
	);

	always #1 clk = ~clk;

	always @(negedge clk) begin
		out_ready = ($urandom_range(99) >= recv_idle_pct);
	end

	task automatic report_mismatch(input string msg);
		$display("%0t ns: mismatch: %s", $time, msg);
		mismatch_count++;
	endtask

	task automatic queue_record_byte(input logic kind, input logic [7:0] b, input logic first);
		sfr_pkg::result_t r;
		r.kind  = kind;
		r.rbyte = b;
		r.first = first;
		r.last  = 1'b0;
		expected_record_bytes.push_back(r);
	endtask

	task automatic restart_record(input logic [15:0] addr);
		shadow_addr = addr;
		shadow_fill = 0;
		shadow_sum  = addr[15:8] + addr[7:0];
	endtask

	task automatic emit_s1_record();
		logic [7:0] cnt;
		if (shadow_fill == 0)
			return;
		cnt = 8'(shadow_fill) + sfr_pkg::HDR_BYTES;
		queue_record_byte(sfr_pkg::KIND_S1, cnt, 1'b1);
		queue_record_byte(sfr_pkg::KIND_S1, shadow_addr[15:8], 1'b0);
		queue_record_byte(sfr_pkg::KIND_S1, shadow_addr[7:0], 1'b0);
		for (int i = 0; i < shadow_fill; i++)
			queue_record_byte(sfr_pkg::KIND_S1, shadow_data[i], 1'b0);
		queue_record_byte(sfr_pkg::KIND_S1, ~(shadow_sum + cnt), 1'b0);
		restart_record(shadow_addr + 16'(shadow_fill));
	endtask

	task automatic buffer_data_byte(input logic [7:0] b);
		if (shadow_fill >= REC_MAX)
			emit_s1_record();
		shadow_data[shadow_fill] = b;
		shadow_fill++;
		shadow_sum += b;
	endtask

	// expected record bytes for one accepted transaction
	task automatic predict_records(input logic [2:0] op, input logic [15:0] val);
		int unsigned      n_before;
		sfr_pkg::result_t tail;
		n_before = expected_record_bytes.size();
		case (op)
			sfr_pkg::OP_BYTE: buffer_data_byte(val[7:0]);
			sfr_pkg::OP_WORD: begin
				buffer_data_byte(val[7:0]);
				buffer_data_byte(val[15:8]);
			end
			sfr_pkg::OP_START: restart_record(val);
			sfr_pkg::OP_FLUSH: emit_s1_record();
			sfr_pkg::OP_END: begin
				emit_s1_record();
				queue_record_byte(sfr_pkg::KIND_S9, sfr_pkg::S9_COUNT, 1'b1);
				queue_record_byte(sfr_pkg::KIND_S9, val[15:8], 1'b0);
				queue_record_byte(sfr_pkg::KIND_S9, val[7:0], 1'b0);
				queue_record_byte(sfr_pkg::KIND_S9,
					~(sfr_pkg::S9_COUNT + val[15:8] + val[7:0]), 1'b0);
				restart_record(shadow_addr);
			end
			default: ;
		endcase
		if (expected_record_bytes.size() > n_before) begin
			tail = expected_record_bytes.pop_back();
			tail.last = 1'b1;
			expected_record_bytes.push_back(tail);
		end
	endtask

	task automatic send_item(input logic [2:0] op, input logic [15:0] val);
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid = 1'b0;
			@(negedge clk);
		end
		in_valid = 1'b1;
		opcode   = op;
		value    = val;
		forever begin
			@(posedge clk);
			if (in_ready)
				break;
		end
		predict_records(op, val);
		if (op <= sfr_pkg::OP_END)
			items_sent++;
	endtask

	task automatic wait_all_records(input int unsigned tail_cycles);
		@(negedge clk);
		in_valid = 1'b0;
		while (expected_record_bytes.size() != 0)
			@(posedge clk);
		repeat (tail_cycles) @(posedge clk);
	endtask

	always @(posedge clk) begin
		sfr_pkg::result_t exp_r;
		if (arst_n && out_valid && out_ready) begin
			if (expected_record_bytes.size() == 0) begin
				report_mismatch($sformatf("unexpected record byte %02h", record_byte));
			end else begin
				exp_r = expected_record_bytes.pop_front();
				if (record_kind !== exp_r.kind)
					report_mismatch($sformatf("record_kind %b, want %b",
						record_kind, exp_r.kind));
				if (record_byte !== exp_r.rbyte)
					report_mismatch($sformatf("record_byte %02h, want %02h",
						record_byte, exp_r.rbyte));
				if (first_of_record !== exp_r.first)
					report_mismatch($sformatf("first_of_record %b, want %b",
						first_of_record, exp_r.first));
				if (last_of_run !== exp_r.last)
					report_mismatch($sformatf("last_of_run %b, want %b",
						last_of_run, exp_r.last));
			end
		end
	end

	// unused opcodes, flush and end with nothing buffered, S9 address extremes
	task automatic test_empty_buffer_cases();
		send_item(3'd5, 16'hFFFF);
		send_item(3'd6, 16'h0000);
		send_item(3'd7, 16'hA5A5);
		send_item(sfr_pkg::OP_FLUSH, 16'h0000);
		send_item(sfr_pkg::OP_END, 16'h0000);
		send_item(sfr_pkg::OP_END, 16'hFFFF);
	endtask

	// fill to capacity near the top of the address space; overflow byte forces
	// the flush and the next record address wraps past 0xFFFF
	task automatic test_full_record_wrap();
		send_item(sfr_pkg::OP_START, 16'hFFF0);
		send_item(sfr_pkg::OP_WORD, 16'h00FF);
		for (int i = 0; i < REC_MAX / 2 - 1; i++)
			send_item(sfr_pkg::OP_WORD, 16'($urandom));
		send_item(sfr_pkg::OP_BYTE, 16'hFFFF);
		send_item(sfr_pkg::OP_BYTE, 16'h0000);
		send_item(sfr_pkg::OP_END, 16'h8001);
	endtask

	// mostly well-formed records with random content, some noise transactions
	task automatic test_random_records(input int unsigned n_items);
		int unsigned target;
		int unsigned n_bytes;
		int unsigned closing;
		logic [15:0] addr;
		target = items_sent + n_items;
		while (items_sent < target) begin
			if ($urandom_range(99) < 85) begin
				addr = ($urandom_range(7) == 0) ? 16'hFFFF - 16'($urandom_range(40))
					: 16'($urandom);
				send_item(sfr_pkg::OP_START, addr);
				n_bytes = ($urandom_range(9) == 0) ? $urandom_range(20, 80)
					: $urandom_range(1, 12);
				while (n_bytes > 0) begin
					if ($urandom_range(19) == 0)
						send_item(sfr_pkg::OP_FLUSH, 16'($urandom));
					if (n_bytes >= 2 && $urandom_range(1)) begin
						send_item(sfr_pkg::OP_WORD, 16'($urandom));
						n_bytes -= 2;
					end else begin
						send_item(sfr_pkg::OP_BYTE, 16'($urandom));
						n_bytes--;
					end
				end
				closing = $urandom_range(9);
				if (closing < 5)
					send_item(sfr_pkg::OP_FLUSH, 16'($urandom));
				else if (closing < 9)
					send_item(sfr_pkg::OP_END, 16'($urandom));
			end else begin
				send_item(3'($urandom_range(7)), 16'($urandom));
			end
		end
	endtask

	initial begin
		for (int i = 0; i < REC_MAX; i++)
			shadow_data[i] = '0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		send_idle_pct = 38;
		recv_idle_pct = 48;
		test_empty_buffer_cases();
		test_full_record_wrap();
		test_random_records(160);
		wait_all_records(0);

		send_idle_pct = 48;
		recv_idle_pct = 38;
		test_random_records(160);
		wait_all_records(0);

		send_idle_pct = 0;
		recv_idle_pct = 0;
		test_random_records(160);
		wait_all_records(100);

		if (mismatch_count == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

	initial begin
		#(TIMEOUT_NS);
		$display("timeout with %0d record bytes outstanding", expected_record_bytes.size());
		$display("*** FAILED ***");
		$finish;
	end

endmodule

/* srecord_s19_framer.f */
+incdir+rtl
rtl/sfr_pkg.sv
rtl/sfr_buf.sv
rtl/sfr_out.sv
rtl/srecord_s19_framer.sv
test/tb_srecord_s19_framer.sv
